// File: rtl/core/tgc_pkg.sv
// Touch gesture classifier: shared types, codes and constants.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package tgc_pkg;

    localparam int CoordBits  = 12;
    localparam int RadiusBits = 12;
    localparam int TimeBits   = 32;
    localparam int CfgIdxBits = 2;
    localparam int CfgDataBits = 32;

    // tan(22.5 deg) and tan(67.5 deg), Q8
    localparam int TanLoQ8 = 106;
    localparam int TanHiQ8 = 618;

    localparam logic [RadiusBits-1:0] TapRadiusRst    = RadiusBits'(40);
    localparam logic [TimeBits-1:0]   HoldTimeRst     = TimeBits'(160000);
    localparam logic [TimeBits-1:0]   WaitTimeRst     = TimeBits'(120000);
    localparam logic [TimeBits-1:0]   DtapWindowRst   = TimeBits'(200000);

    typedef enum logic [3:0] {
        G_NONE      = 4'd0,
        G_TOUCH     = 4'd1,
        G_WAIT      = 4'd2,
        G_MOVE      = 4'd3,
        G_DRAG      = 4'd4,
        G_TAP       = 4'd5,
        G_DTAP      = 4'd6,
        G_RIGHT     = 4'd7,
        G_DOWNRIGHT = 4'd8,
        G_DOWN      = 4'd9,
        G_DOWNLEFT  = 4'd10,
        G_LEFT      = 4'd11,
        G_UPLEFT    = 4'd12,
        G_UP        = 4'd13,
        G_UPRIGHT   = 4'd14
    } t_gesture;

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_TAP_RADIUS = 2'd0,
        CFG_HOLD_TIME  = 2'd1,
        CFG_WAIT_TIME  = 2'd2,
        CFG_DTAP_WIN   = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

// File: rtl/core/tgc_if.sv
// Touch gesture classifier: sample, result and register-write channels.
// Depends on tgc_pkg for field widths and the gesture type.
`default_nettype none

interface tgc_sample_if;
    logic                               valid;
    logic                               ready;
    logic                               touched;
    logic [tgc_pkg::CoordBits-1:0]      pos_x;
    logic [tgc_pkg::CoordBits-1:0]      pos_y;
    logic [tgc_pkg::TimeBits-1:0]       now_us;

    modport source (output valid, touched, pos_x, pos_y, now_us, input ready);
    modport sink   (input valid, touched, pos_x, pos_y, now_us, output ready);
endinterface

interface tgc_result_if;
    logic                               valid;
    logic                               ready;
    tgc_pkg::t_gesture                  gesture;
    tgc_pkg::t_gesture                  previous_gesture;
    logic [tgc_pkg::CoordBits-1:0]      cur_x;
    logic [tgc_pkg::CoordBits-1:0]      cur_y;

    modport source (output valid, gesture, previous_gesture, cur_x, cur_y, input ready);
    modport sink   (input valid, gesture, previous_gesture, cur_x, cur_y, output ready);
endinterface

interface tgc_cfg_if;
    logic                               valid;
    logic                               ready;
    tgc_pkg::t_cfg_idx                  index;
    logic [tgc_pkg::CfgDataBits-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/touch_gesture_classifier.sv
// Touch gesture classifier top level: sample register, classifier, result register.
// Depends on tgc_pkg and the channel interfaces in tgc_if.sv.
//
//   channel    dir  request carries
//   i_sample   in   touched, pos_x, pos_y, now_us
//   o_result   out  gesture, previous_gesture, cur_x, cur_y
//   i_cfg      in   index, data (register write)
//
// One request per cycle sustained while o_result is not stalled; each accepted sample is
// captured in the sample register, then goes through the classifier into the result register.
// Gesture state is updated as a sample moves into the result register.
// A stalled result holds both stages; i_sample.ready drops only when both are full.
// Register writes are always ready. Reset restores settings and gesture state and empties
// both stages.
`default_nettype none

module touch_gesture_classifier (
    input  wire             i_clk,
    input  wire             i_rst_n,
    tgc_sample_if.sink      i_sample,
    tgc_result_if.source    o_result,
    tgc_cfg_if.sink         i_cfg
);

    localparam int CB = tgc_pkg::CoordBits;
    localparam int TB = tgc_pkg::TimeBits;
    localparam int RB = tgc_pkg::RadiusBits;
    localparam int SqW = 2 * CB;
    localparam int D2W = 2 * CB + 1;
    localparam int R2W = 2 * RB;
    localparam int CmpW = (D2W > R2W) ? D2W : R2W;
    localparam int SlW = CB + 10;

    // configuration
    logic [R2W-1:0] r_r2;
    logic [TB-1:0]  r_hold_time, r_wait_time, r_dtap_win;
    logic [RB-1:0]  cfg_radius;

    // pipeline control
    logic           r_s1_vld, r_out_vld;
    logic           out_free, adv;

    // sample register
    logic           r_s1_touched;
    logic [CB-1:0]  r_s1_x, r_s1_y;
    logic [TB-1:0]  r_s1_now;

    // gesture state
    logic           r_was_touched;
    logic [CB-1:0]  r_last_x, r_last_y, r_start_x, r_start_y, r_tap_x, r_tap_y;
    logic [TB-1:0]  r_start_time, r_tap_time;
    tgc_pkg::t_gesture r_cur_g, r_prior_g;

    // result register
    tgc_pkg::t_gesture r_out_g, r_out_prev;
    logic [CB-1:0]  r_out_x, r_out_y;

    // classifier
    logic           press, hold, release_s, is_tap;
    logic [CB-1:0]  n_last_x, n_last_y;
    logic [TB-1:0]  elapsed, tap_gap;
    logic signed [CB:0] dx, dy, tdx, tdy;
    logic [CB-1:0]  ax, ay, tax, tay;
    logic [D2W-1:0] d2_start, d2_tap;
    logic [CmpW-1:0] d2s_c, d2t_c, r2_c;
    logic [SlW-1:0] ay_q8, ax_lo, ax_hi;
    tgc_pkg::t_gesture n_gesture, n_prior, flick_g;

    assign cfg_radius  = i_cfg.data[RB-1:0];
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r2        <= R2W'(tgc_pkg::TapRadiusRst) * R2W'(tgc_pkg::TapRadiusRst);
            r_hold_time <= tgc_pkg::HoldTimeRst;
            r_wait_time <= tgc_pkg::WaitTimeRst;
            r_dtap_win  <= tgc_pkg::DtapWindowRst;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tgc_pkg::CFG_TAP_RADIUS: r_r2 <= R2W'(cfg_radius) * R2W'(cfg_radius);
                tgc_pkg::CFG_HOLD_TIME:  r_hold_time <= i_cfg.data[TB-1:0];
                tgc_pkg::CFG_WAIT_TIME:  r_wait_time <= i_cfg.data[TB-1:0];
                tgc_pkg::CFG_DTAP_WIN:   r_dtap_win  <= i_cfg.data[TB-1:0];
                default: ;
            endcase
        end
    end

    assign out_free       = !r_out_vld || o_result.ready;
    assign adv            = r_s1_vld && out_free;
    assign i_sample.ready = !r_s1_vld || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_sample.ready) begin
                r_s1_vld <= i_sample.valid;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_s1_touched <= i_sample.touched;
            r_s1_x       <= i_sample.pos_x;
            r_s1_y       <= i_sample.pos_y;
            r_s1_now     <= i_sample.now_us;
        end
    end

    always_comb begin
        press     = !r_was_touched && r_s1_touched;
        hold      = r_was_touched && r_s1_touched;
        release_s = r_was_touched && !r_s1_touched;
        n_last_x  = r_s1_touched ? r_s1_x : r_last_x;
        n_last_y  = r_s1_touched ? r_s1_y : r_last_y;
        elapsed   = r_s1_now - r_start_time;
        tap_gap   = r_start_time - r_tap_time;

        dx  = $signed({1'b0, n_last_x}) - $signed({1'b0, r_start_x});
        dy  = $signed({1'b0, n_last_y}) - $signed({1'b0, r_start_y});
        tdx = $signed({1'b0, n_last_x}) - $signed({1'b0, r_tap_x});
        tdy = $signed({1'b0, n_last_y}) - $signed({1'b0, r_tap_y});
        ax  = dx[CB]  ? CB'(-dx)  : dx[CB-1:0];
        ay  = dy[CB]  ? CB'(-dy)  : dy[CB-1:0];
        tax = tdx[CB] ? CB'(-tdx) : tdx[CB-1:0];
        tay = tdy[CB] ? CB'(-tdy) : tdy[CB-1:0];

        d2_start = D2W'(SqW'(ax) * SqW'(ax)) + D2W'(SqW'(ay) * SqW'(ay));
        d2_tap   = D2W'(SqW'(tax) * SqW'(tax)) + D2W'(SqW'(tay) * SqW'(tay));
        d2s_c    = CmpW'(d2_start);
        d2t_c    = CmpW'(d2_tap);
        r2_c     = CmpW'(r_r2);

        // Q8 slope sectors
        ay_q8 = SlW'({ay, 8'd0});
        ax_lo = SlW'(ax) * SlW'(tgc_pkg::TanLoQ8);
        ax_hi = SlW'(ax) * SlW'(tgc_pkg::TanHiQ8);
        if (ay_q8 <= ax_lo) begin
            flick_g = dx[CB] ? tgc_pkg::G_LEFT : tgc_pkg::G_RIGHT;
        end else if (ay_q8 > ax_hi) begin
            flick_g = (!dy[CB] && dy != '0) ? tgc_pkg::G_DOWN : tgc_pkg::G_UP;
        end else if (!dy[CB] && dy != '0) begin
            flick_g = (!dx[CB] && dx != '0) ? tgc_pkg::G_DOWNRIGHT : tgc_pkg::G_DOWNLEFT;
        end else begin
            flick_g = (!dx[CB] && dx != '0) ? tgc_pkg::G_UPRIGHT : tgc_pkg::G_UPLEFT;
        end

        is_tap    = 1'b0;
        n_gesture = tgc_pkg::G_NONE;
        if (press) begin
            n_gesture = tgc_pkg::G_TOUCH;
        end else if (hold) begin
            n_gesture = (elapsed > r_hold_time) ? tgc_pkg::G_MOVE : tgc_pkg::G_WAIT;
        end else if (release_s) begin
            if (elapsed > r_wait_time && elapsed <= r_hold_time) begin
                if (d2s_c <= r2_c) begin
                    n_gesture = tgc_pkg::G_WAIT;
                end
            end else if (elapsed > r_hold_time) begin
                n_gesture = tgc_pkg::G_DRAG;
            end else if (d2s_c <= r2_c) begin
                is_tap    = 1'b1;
                n_gesture = (tap_gap < r_dtap_win && d2t_c < r2_c) ?
                            tgc_pkg::G_DTAP : tgc_pkg::G_TAP;
            end else begin
                n_gesture = flick_g;
            end
        end

        n_prior = (r_cur_g != tgc_pkg::G_NONE) ? r_cur_g : r_prior_g;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_touched <= 1'b0;
            r_last_x      <= '0;
            r_last_y      <= '0;
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_start_time  <= '0;
            r_tap_time    <= '0;
            r_tap_x       <= '0;
            r_tap_y       <= '0;
            r_cur_g       <= tgc_pkg::G_NONE;
            r_prior_g     <= tgc_pkg::G_NONE;
        end else if (adv) begin
            r_was_touched <= r_s1_touched;
            r_last_x      <= n_last_x;
            r_last_y      <= n_last_y;
            r_cur_g       <= n_gesture;
            r_prior_g     <= n_prior;
            if (press) begin
                r_start_x    <= n_last_x;
                r_start_y    <= n_last_y;
                r_start_time <= r_s1_now;
            end
            if (is_tap) begin
                r_tap_time <= r_s1_now;
                r_tap_x    <= n_last_x;
                r_tap_y    <= n_last_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_g    <= n_gesture;
            r_out_prev <= n_prior;
            r_out_x    <= n_last_x;
            r_out_y    <= n_last_y;
        end
    end

    assign o_result.valid            = r_out_vld;
    assign o_result.gesture          = r_out_g;
    assign o_result.previous_gesture = r_out_prev;
    assign o_result.cur_x            = r_out_x;
    assign o_result.cur_y            = r_out_y;

    a_press_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_gesture == tgc_pkg::G_TOUCH |=>
            r_was_touched && r_start_time == $past(r_s1_now))
        else $error("press did not capture start time");

    a_tap_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (n_gesture == tgc_pkg::G_TAP || n_gesture == tgc_pkg::G_DTAP) |=>
            r_tap_time == $past(r_s1_now) && !r_was_touched)
        else $error("tap did not record its time");

    a_move_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_gesture == tgc_pkg::G_MOVE |-> r_was_touched && r_s1_touched)
        else $error("move reported without a held touch");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld && r_out_g == r_cur_g)
        else $error("result register out of step with gesture state");

endmodule

`default_nettype wire

// File: dv/touch_gesture_classifier_chk.sv
// Checker for the touch gesture classifier: watches the sample, result and register
// channels, predicts each result and compares it field by field.
// Depends on tgc_pkg and the channel interfaces in tgc_if.sv.
module touch_gesture_classifier_chk
    import tgc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    tgc_sample_if   i_sample,
    tgc_result_if   i_result,
    tgc_cfg_if      i_cfg,
    output int      o_errors,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_gesture               gesture;
        t_gesture               previous_gesture;
        logic [CoordBits-1:0]   cur_x;
        logic [CoordBits-1:0]   cur_y;
    } gesture_event_t;

    gesture_event_t predicted_events[$];

    logic [RadiusBits-1:0]  tap_radius;
    logic [TimeBits-1:0]    hold_time_us;
    logic [TimeBits-1:0]    wait_time_us;
    logic [TimeBits-1:0]    dtap_window_us;

    logic                   was_touched;
    logic [CoordBits-1:0]   last_x, last_y, start_x, start_y, tap_x, tap_y;
    logic [TimeBits-1:0]    start_time, tap_time;
    t_gesture               cur_gesture, prior_gesture;

    function automatic int dist_sq(logic [CoordBits-1:0] x0, y0, x1, y1);
        int dx, dy;
        dx = int'(x1) - int'(x0);
        dy = int'(y1) - int'(y0);
        return dx * dx + dy * dy;
    endfunction

    // y grows downward, so a positive dy is a downward stroke
    function automatic t_gesture flick_sector(int dx, int dy);
        int ax, ay;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ay * 256 <= ax * TanLoQ8) begin
            if (dx >= 0) return G_RIGHT;
            return G_LEFT;
        end
        if (ay * 256 > ax * TanHiQ8) begin
            if (dy > 0) return G_DOWN;
            return G_UP;
        end
        if (dy > 0) begin
            if (dx > 0) return G_DOWNRIGHT;
            return G_DOWNLEFT;
        end
        if (dx > 0) return G_UPRIGHT;
        return G_UPLEFT;
    endfunction

    function automatic gesture_event_t classify_sample(logic touched,
                                                       logic [CoordBits-1:0] px, py,
                                                       logic [TimeBits-1:0] now);
        gesture_event_t         ev;
        t_gesture               g;
        logic [TimeBits-1:0]    elapsed;
        int                     d2, r2;
        g  = G_NONE;
        r2 = int'(tap_radius) * int'(tap_radius);
        if (cur_gesture != G_NONE) prior_gesture = cur_gesture;
        if (touched) begin
            last_x = px;
            last_y = py;
        end
        elapsed = now - start_time;
        d2      = dist_sq(start_x, start_y, last_x, last_y);
        if (!was_touched && touched) begin
            start_x    = last_x;
            start_y    = last_y;
            start_time = now;
            g          = G_TOUCH;
        end else if (was_touched && touched) begin
            if (elapsed > hold_time_us) g = G_MOVE;
            else g = G_WAIT;
        end else if (was_touched) begin
            if (elapsed > wait_time_us && elapsed <= hold_time_us) begin
                if (d2 <= r2) g = G_WAIT;
            end else if (elapsed > hold_time_us) begin
                g = G_DRAG;
            end else if (d2 <= r2) begin
                g = G_TAP;
                if ((start_time - tap_time) < dtap_window_us &&
                    dist_sq(tap_x, tap_y, last_x, last_y) < r2) g = G_DTAP;
                tap_time = now;
                tap_x    = last_x;
                tap_y    = last_y;
            end else begin
                g = flick_sector(int'(last_x) - int'(start_x), int'(last_y) - int'(start_y));
            end
        end
        was_touched         = touched;
        cur_gesture         = g;
        ev.gesture          = g;
        ev.previous_gesture = prior_gesture;
        ev.cur_x            = last_x;
        ev.cur_y            = last_y;
        return ev;
    endfunction

    task automatic compare_field(input string name, input logic [CoordBits-1:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        gesture_event_t want;
        if (!i_rst_n) begin
            tap_radius     = TapRadiusRst;
            hold_time_us   = HoldTimeRst;
            wait_time_us   = WaitTimeRst;
            dtap_window_us = DtapWindowRst;
            was_touched    = 1'b0;
            last_x         = '0;
            last_y         = '0;
            start_x        = '0;
            start_y        = '0;
            tap_x          = '0;
            tap_y          = '0;
            start_time     = '0;
            tap_time       = '0;
            cur_gesture    = G_NONE;
            prior_gesture  = G_NONE;
            predicted_events.delete();
            o_errors       = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_TAP_RADIUS: tap_radius     = i_cfg.data[RadiusBits-1:0];
                    CFG_HOLD_TIME:  hold_time_us   = i_cfg.data;
                    CFG_WAIT_TIME:  wait_time_us   = i_cfg.data;
                    CFG_DTAP_WIN:   dtap_window_us = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (predicted_events.size() == 0) begin
                    $error("result request with no sample outstanding");
                    o_errors++;
                end else begin
                    want = predicted_events.pop_front();
                    compare_field("gesture", CoordBits'(want.gesture),
                                  CoordBits'(i_result.gesture));
                    compare_field("previous_gesture", CoordBits'(want.previous_gesture),
                                  CoordBits'(i_result.previous_gesture));
                    compare_field("cur_x", want.cur_x, i_result.cur_x);
                    compare_field("cur_y", want.cur_y, i_result.cur_y);
                end
            end
            if (i_sample.valid && i_sample.ready) begin
                predicted_events.push_back(classify_sample(i_sample.touched, i_sample.pos_x,
                                                           i_sample.pos_y, i_sample.now_us));
            end
        end
        o_pending = predicted_events.size();
    end

endmodule

// File: dv/touch_gesture_classifier_tb.sv
// Testbench top for the touch gesture classifier: clock, reset, stroke stimulus,
// register settings, result back-pressure, watchdog and verdict.
// Depends on tgc_pkg, tgc_if.sv, the block and touch_gesture_classifier_chk.
module touch_gesture_classifier_tb;
    import tgc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit    = 2000;
    localparam int NumPhases     = 6;
    localparam int ItemsPerPhase = 305;
    localparam int CoordMax      = (1 << CoordBits) - 1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tgc_sample_if sample_ch ();
    tgc_result_if result_ch ();
    tgc_cfg_if    cfg_ch ();

    int n_errors, n_pending;
    int idle_cycles;
    int n_sent;
    int burst_left;
    bit gappy;
    bit hold_req;

    logic [RadiusBits-1:0]  cfg_radius;
    logic [TimeBits-1:0]    cfg_hold, cfg_wait, cfg_dtap;
    logic [TimeBits-1:0]    t_now;
    logic [CoordBits-1:0]   prev_x, prev_y;

    touch_gesture_classifier u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    touch_gesture_classifier_chk u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (sample_ch),
        .i_result  (result_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (n_errors),
        .o_pending (n_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == StallLimit) begin
            $display("touch_gesture_classifier_tb: done, errors");
            $finish;
        end
    end

    // result back-pressure: segments of free flow, random and periodic stalls,
    // plus one long hold-off so the pipeline fills and the sample channel stalls
    initial begin : result_stall
        int  seg_len, mode, k;
        bit  held;
        result_ch.ready = 1'b0;
        held = 1'b0;
        k = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                result_ch.ready = 1'b0;
                repeat (120) @(negedge i_clk);
            end else begin
                mode    = $urandom_range(0, 3);
                seg_len = $urandom_range(8, 80);
                repeat (seg_len) begin
                    k++;
                    case (mode)
                        0: result_ch.ready = 1'b1;
                        1: result_ch.ready = 1'($urandom_range(0, 1));
                        2: result_ch.ready = (k % 3) != 0;
                        default: result_ch.ready = ($urandom_range(0, 4) == 0);
                    endcase
                    @(negedge i_clk);
                end
            end
        end
    end

    task automatic send_sample(input bit touched, input logic [CoordBits-1:0] x, y,
                               input logic [TimeBits-1:0] ts);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gappy) begin
                sample_ch.valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        burst_left--;
        sample_ch.valid   = 1'b1;
        sample_ch.touched = touched;
        sample_ch.pos_x   = x;
        sample_ch.pos_y   = y;
        sample_ch.now_us  = ts;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CfgDataBits-1:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        case (idx)
            CFG_TAP_RADIUS: cfg_radius = value[RadiusBits-1:0];
            CFG_HOLD_TIME:  cfg_hold   = value;
            CFG_WAIT_TIME:  cfg_wait   = value;
            CFG_DTAP_WIN:   cfg_dtap   = value;
            default: ;
        endcase
    endtask

    task automatic settle();
        sample_ch.valid = 1'b0;
        while (n_pending != 0) @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [RadiusBits-1:0] radius,
                                 input logic [TimeBits-1:0] hold_us, wait_us, dtap_us);
        logic [CfgDataBits-1:0] junk;
        junk = $urandom();
        write_reg(CFG_TAP_RADIUS, {junk[CfgDataBits-1:RadiusBits], radius});
        write_reg(CFG_HOLD_TIME, hold_us);
        write_reg(CFG_WAIT_TIME, wait_us);
        write_reg(CFG_DTAP_WIN, dtap_us);
    endtask

    function automatic logic [CoordBits-1:0] clamp_coord(int v, int lo, int hi);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return CoordBits'(v);
    endfunction

    function automatic logic [CoordBits-1:0] rand_coord();
        return CoordBits'($urandom_range(0, CoordMax));
    endfunction

    // one stroke (press, zero or more hold samples, release) with timing and travel aimed at the thresholds
    task automatic do_stroke();
        logic [CoordBits-1:0]   x0, y0, x1, y1, hx, hy;
        logic [TimeBits-1:0]    dur, t0, th;
        int                     r, hm, dx, dy, lo, hi, nh;
        bit                     free_ends, near;
        r         = int'(cfg_radius);
        dx        = 0;
        dy        = 0;
        free_ends = 1'b0;
        near      = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 6))
            0: ;
            1: begin
                hm = r / 2;
                dx = int'($urandom_range(0, 2 * hm)) - hm;
                dy = int'($urandom_range(0, 2 * hm)) - hm;
            end
            2: begin
                if ($urandom_range(0, 1)) dx = r;
                else dy = r;
            end
            3: begin
                if ($urandom_range(0, 1)) dx = r + 1;
                else dy = r + 1;
            end
            4: begin
                dx = 128;
                case ($urandom_range(0, 3))
                    0: dy = 53;
                    1: dy = 54;
                    2: dy = 309;
                    default: dy = 310;
                endcase
            end
            default: free_ends = 1'b1;
        endcase
        if (free_ends) begin
            x0 = rand_coord();
            y0 = rand_coord();
            x1 = rand_coord();
            y1 = rand_coord();
        end else begin
            if ($urandom_range(0, 1)) dx = -dx;
            if ($urandom_range(0, 1)) dy = -dy;
            if (dx > CoordMax) dx = CoordMax;
            if (dx < -CoordMax) dx = -CoordMax;
            if (dy > CoordMax) dy = CoordMax;
            if (dy < -CoordMax) dy = -CoordMax;
            lo = (dx < 0) ? -dx : 0;
            hi = (dx > 0) ? CoordMax - dx : CoordMax;
            x0 = near ? clamp_coord(int'(prev_x), lo, hi) : CoordBits'($urandom_range(lo, hi));
            lo = (dy < 0) ? -dy : 0;
            hi = (dy > 0) ? CoordMax - dy : CoordMax;
            y0 = near ? clamp_coord(int'(prev_y), lo, hi) : CoordBits'($urandom_range(lo, hi));
            x1 = CoordBits'(int'(x0) + dx);
            y1 = CoordBits'(int'(y0) + dy);
        end
        nh = $urandom_range(0, 4);
        if (nh == 0) begin
            x1 = x0;
            y1 = y0;
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: dur = $urandom_range(0, cfg_wait);
            4, 5: begin
                case ($urandom_range(0, 4))
                    0: dur = '0;
                    1: dur = cfg_wait;
                    2: dur = cfg_wait + 1;
                    3: dur = cfg_hold;
                    default: dur = cfg_hold + 1;
                endcase
            end
            6: dur = (cfg_wait < cfg_hold) ? $urandom_range(cfg_wait + 1, cfg_hold) : cfg_hold;
            7, 8: dur = cfg_hold + $urandom_range(1, 400000);
            default: dur = $urandom();
        endcase
        case ($urandom_range(0, 4))
            0: t_now += $urandom_range(0, 3000);
            1: t_now += $urandom_range(0, cfg_dtap);
            2: t_now += cfg_dtap;
            3: t_now += cfg_dtap - 1;
            default: t_now += $urandom();
        endcase
        t0 = t_now;
        send_sample(1'b1, x0, y0, t0);
        for (int i = 1; i <= nh; i++) begin
            if (i == nh) begin
                hx = x1;
                hy = y1;
            end else begin
                hx = rand_coord();
                hy = rand_coord();
            end
            th = (i == nh && $urandom_range(0, 3) == 0) ? dur : $urandom_range(0, dur);
            send_sample(1'b1, hx, hy, t0 + th);
        end
        send_sample(1'b0, rand_coord(), rand_coord(), t0 + dur);
        t_now  = t0 + dur;
        prev_x = x1;
        prev_y = y1;
        repeat ($urandom_range(0, 2)) begin
            send_sample(1'b0, rand_coord(), rand_coord(), $urandom());
        end
    endtask

    // broken sequences: arbitrary touched bits and positions, timestamps up to the hold time past t_now
    task automatic noise_burst();
        repeat ($urandom_range(1, 4)) begin
            send_sample(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                        t_now + $urandom_range(0, cfg_hold));
        end
    endtask

    initial begin : stimulus
        int target;
        i_rst_n           = 1'b0;
        sample_ch.valid   = 1'b0;
        sample_ch.touched = 1'b0;
        sample_ch.pos_x   = '0;
        sample_ch.pos_y   = '0;
        sample_ch.now_us  = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_TAP_RADIUS;
        cfg_ch.data       = '0;
        hold_req          = 1'b0;
        gappy             = 1'b0;
        burst_left        = 0;
        n_sent            = 0;
        cfg_radius        = TapRadiusRst;
        cfg_hold          = HoldTimeRst;
        cfg_wait          = WaitTimeRst;
        cfg_dtap          = DtapWindowRst;
        prev_x            = '0;
        prev_y            = '0;
        t_now             = $urandom();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: idle, hold/move edge, drag, tap, double tap, wait edges,
        // moved wait release, flicks and timestamp wrap
        send_sample(1'b0, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
        send_sample(1'b1, 12'd0, 12'd0, 32'd1000);
        send_sample(1'b1, 12'd4095, 12'd0, 32'd161000);
        send_sample(1'b1, 12'd4095, 12'd4095, 32'd161001);
        send_sample(1'b0, 12'd0, 12'd0, 32'd161001);
        send_sample(1'b1, 12'd4095, 12'd4095, 32'd170000);
        send_sample(1'b0, 12'd0, 12'd0, 32'd170100);
        send_sample(1'b1, 12'd4090, 12'd4095, 32'd200000);
        send_sample(1'b0, 12'd1234, 12'd2345, 32'd200050);
        send_sample(1'b1, 12'd2000, 12'd2000, 32'd500000);
        send_sample(1'b0, 12'd0, 12'd0, 32'd620000);
        send_sample(1'b1, 12'd2000, 12'd2000, 32'd700000);
        send_sample(1'b0, 12'd0, 12'd0, 32'd820001);
        send_sample(1'b1, 12'd100, 12'd100, 32'd900000);
        send_sample(1'b1, 12'd200, 12'd100, 32'd900010);
        send_sample(1'b0, 12'd0, 12'd0, 32'd1020001);
        send_sample(1'b1, 12'd1000, 12'd1000, 32'd1100000);
        send_sample(1'b1, 12'd1100, 12'd1000, 32'd1100010);
        send_sample(1'b0, 12'd0, 12'd0, 32'd1100020);
        send_sample(1'b1, 12'd1000, 12'd1000, 32'd1200000);
        send_sample(1'b1, 12'd900, 12'd900, 32'd1200010);
        send_sample(1'b0, 12'd0, 12'd0, 32'd1200020);
        send_sample(1'b1, 12'd50, 12'd50, 32'hFFFF_FFF0);
        send_sample(1'b0, 12'd0, 12'd0, 32'h0000_0010);

        for (int ph = 0; ph < NumPhases; ph++) begin
            settle();
            case (ph)
                0: load_settings(TapRadiusRst, HoldTimeRst, WaitTimeRst, DtapWindowRst);
                1: load_settings('0, '0, '0, '0);
                2: load_settings('1, '1, '1, '1);
                3: load_settings(12'd200, 32'd50000, 32'd90000, 32'd300000);
                4: load_settings(RadiusBits'($urandom_range(0, CoordMax)),
                                 $urandom_range(0, 400000),
                                 $urandom_range(0, 400000), $urandom_range(0, 400000));
                default: load_settings(12'd1000, 32'd1000000, 32'd10, 32'h8000_0000);
            endcase
            gappy = ($urandom_range(0, 2) != 0);
            if (ph == 0) hold_req = 1'b1;
            target = n_sent + ItemsPerPhase;
            while (n_sent < target) begin
                if ($urandom_range(0, 9) == 0) noise_burst();
                else do_stroke();
            end
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("touch_gesture_classifier_tb: done, clean");
        end else begin
            $display("touch_gesture_classifier_tb: done, errors");
        end
        $finish;
    end

endmodule
